FILE: rtl/sctl_pkg.sv
// ----------------------------------------------------------------------------
// sctl_pkg
// Shared constants and types for the sector cache tag and lru controller.
// ----------------------------------------------------------------------------
package sctl_pkg;
  localparam int SLOTS = 64;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int SECTOR_BITS = 32;
  localparam int STAMP_BITS = 32;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;

  localparam logic [1:0] KIND_WB   = 2'd0;
  localparam logic [1:0] KIND_FILL = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // search token passed along the row, one cell per cycle
  typedef struct packed {
    logic                   hit;
    logic [SLOT_BITS-1:0]   hit_idx;
    logic                   inv;
    logic [SLOT_BITS-1:0]   inv_idx;
    logic [STAMP_BITS-1:0]  best_stamp;
    logic [SLOT_BITS-1:0]   best_idx;
  } srch_t;

  // command broadcast from the sequencer to the cells
  typedef struct packed {
    logic                   wr;      // install or update the addressed slot
    logic [SLOT_BITS-1:0]   idx;
    logic                   set_tag;
    logic [SECTOR_BITS-1:0] tag;
    logic                   set_dirty;
    logic                   dirty;
    logic                   set_stamp;
    logic [STAMP_BITS-1:0]  stamp;
  } cmd_t;
endpackage

FILE: rtl/sctl_cell.sv
// ----------------------------------------------------------------------------
// sctl_cell
// One cache slot: holds valid, dirty, tag and stamp, folds its state into the
// search token passing by and forwards the token to the next cell.
// ----------------------------------------------------------------------------
module sctl_cell
  import sctl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic [SLOT_BITS-1:0]   my_idx,
  input  logic [SECTOR_BITS-1:0] key,
  input  logic                   first,
  input  srch_t                  tok_in,
  output srch_t                  tok_out,
  input  cmd_t                   cmd,
  input  logic                   clean,
  output logic                   valid,
  output logic                   dirty,
  output logic [SECTOR_BITS-1:0] tag
);
  logic [STAMP_BITS-1:0] stamp;
  srch_t t;
  logic  sel;

  assign sel = cmd.wr && (cmd.idx == my_idx);

  always_comb begin
    t = tok_in;
    if (first) begin
      t.hit = 1'b0;
      t.inv = 1'b0;
      t.best_stamp = stamp;
      t.best_idx = my_idx;
      t.hit_idx = '0;
      t.inv_idx = '0;
    end else if (stamp < tok_in.best_stamp) begin
      t.best_stamp = stamp;
      t.best_idx = my_idx;
    end
    if (!t.hit && valid && tag == key) begin
      t.hit = 1'b1;
      t.hit_idx = my_idx;
    end
    if (!t.inv && !valid) begin
      t.inv = 1'b1;
      t.inv_idx = my_idx;
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= t;
    if (rst) begin
      valid <= 1'b0;
      dirty <= 1'b0;
      stamp <= '0;
    end else begin
      if (sel) begin
        valid <= 1'b1;
        if (cmd.set_dirty) dirty <= cmd.dirty;
        if (cmd.set_stamp) stamp <= cmd.stamp;
      end
      if (clean) dirty <= 1'b0;
    end
    if (sel && cmd.set_tag) tag <= cmd.tag;
  end
endmodule

FILE: rtl/sector_cache_tag_lru_controller.sv
// ----------------------------------------------------------------------------
// sector_cache_tag_lru_controller
// Tag, valid, dirty and lru stamp control for a fully associative sector cache.
// ----------------------------------------------------------------------------
// Each access walks a search token down a row of SLOTS cells, one cell per
// cycle, and then emits up to three result beats. A flush scans the dirty
// bits one slot per cycle, pausing on a dirty slot while a held beat waits
// for the output register. One item is in work at a time; results leave
// through an output register that takes a new beat in the same cycle the held
// one is accepted.
module sector_cache_tag_lru_controller
  import sctl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] sector,
  input  logic [31:0] now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [5:0]  slot,
  output logic [31:0] disk_sector,
  output logic        hit,
  output logic        last
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SRCH = 3'd1;
  localparam logic [2:0] ST_DEC  = 3'd2;
  localparam logic [2:0] ST_WB   = 3'd3;
  localparam logic [2:0] ST_FILL = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;
  localparam logic [2:0] ST_FLSH = 3'd6;

  logic [2:0] state;
  logic [1:0] op;
  logic [SECTOR_BITS-1:0] key;
  logic [STAMP_BITS-1:0] tnow;
  logic [SLOT_BITS:0] cnt;
  logic [SLOT_BITS-1:0] vic;
  logic vic_hit;

  // flush beat held back until it is known whether another one follows
  logic pend;
  logic [SLOT_BITS-1:0] pidx;
  logic [SECTOR_BITS-1:0] ptag;

  srch_t tok [SLOTS+1];
  logic [SLOTS-1:0] cv, cd, ccl;
  logic [SECTOR_BITS-1:0] ct [SLOTS];
  cmd_t cmd;
  logic first;

  assign tok[0] = '0;
  assign first = (state == ST_SRCH) && (cnt == '0);

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    sctl_cell u_cell (
      .clk(clk), .rst(rst),
      .my_idx(SLOT_BITS'(g)), .key(key), .first(first && g == 0),
      .tok_in(tok[g]), .tok_out(tok[g+1]),
      .cmd(cmd), .clean(ccl[g]),
      .valid(cv[g]), .dirty(cd[g]), .tag(ct[g])
    );
  end

  logic obuf_free;
  assign obuf_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  logic [SLOT_BITS-1:0] fidx;
  assign fidx = cnt[SLOT_BITS-1:0];

  // dirty slot under the scan pointer is taken into the holding register
  logic fl_take;
  assign fl_take = (state == ST_FLSH) && !cnt[SLOT_BITS] && cd[fidx] &&
                   (!pend || obuf_free);
  logic fl_end;
  assign fl_end = (state == ST_FLSH) && cnt[SLOT_BITS] && pend && obuf_free;

  logic beat_go;
  assign beat_go = ((state inside {ST_WB, ST_FILL, ST_DONE}) && obuf_free) ||
                   (fl_take && pend) || fl_end;

  always_comb begin
    cmd = '0;
    ccl = '0;
    if (fl_take) ccl[fidx] = 1'b1;
    if (state == ST_FILL && obuf_free) begin
      cmd.wr = 1'b1; cmd.idx = vic; cmd.set_tag = 1'b1; cmd.tag = key;
      cmd.set_dirty = 1'b1; cmd.dirty = 1'b0;
    end
    if (state == ST_DONE && obuf_free && op == MODE_WRITE) begin
      cmd.wr = 1'b1; cmd.idx = vic; cmd.set_dirty = 1'b1; cmd.dirty = 1'b1;
      cmd.set_stamp = 1'b1; cmd.stamp = tnow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (beat_go) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      pend <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op <= mode;
            key <= sector;
            tnow <= now;
            cnt <= '0;
            if (mode == MODE_FLUSH) state <= ST_FLSH;
            else if (mode == MODE_READ || mode == MODE_WRITE) state <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          cnt <= cnt + 1'b1;
          if (cnt == (SLOT_BITS+1)'(SLOTS - 1)) state <= ST_DEC;
        end
        ST_DEC: begin
          vic_hit <= tok[SLOTS].hit;
          if (tok[SLOTS].hit) begin
            vic <= tok[SLOTS].hit_idx;
            state <= ST_DONE;
          end else if (tok[SLOTS].inv) begin
            vic <= tok[SLOTS].inv_idx;
            state <= ST_FILL;
          end else begin
            vic <= tok[SLOTS].best_idx;
            state <= cd[tok[SLOTS].best_idx] ? ST_WB : ST_FILL;
          end
        end
        ST_WB: if (obuf_free) begin
          kind <= KIND_WB; slot <= vic;
          disk_sector <= ct[vic]; hit <= 1'b0; last <= 1'b0;
          state <= ST_FILL;
        end
        ST_FILL: if (obuf_free) begin
          kind <= KIND_FILL; slot <= vic;
          disk_sector <= key; hit <= 1'b0; last <= 1'b0;
          state <= ST_DONE;
        end
        ST_DONE: if (obuf_free) begin
          kind <= KIND_DONE; slot <= vic;
          disk_sector <= key; hit <= vic_hit; last <= 1'b1;
          state <= ST_IDLE;
        end
        ST_FLSH: begin
          if (cnt[SLOT_BITS]) begin
            // scan over: the held beat is the final one
            if (!pend) begin
              state <= ST_IDLE;
            end else if (fl_end) begin
              kind <= KIND_WB; slot <= pidx; disk_sector <= ptag;
              hit <= 1'b0; last <= 1'b1;
              pend <= 1'b0;
              state <= ST_IDLE;
            end
          end else if (!cd[fidx]) begin
            cnt <= cnt + 1'b1;
          end else if (fl_take) begin
            // another dirty slot follows, so the held beat goes out now
            if (pend) begin
              kind <= KIND_WB; slot <= pidx; disk_sector <= ptag;
              hit <= 1'b0; last <= 1'b0;
            end
            pend <= 1'b1;
            pidx <= fidx;
            ptag <= ct[fidx];
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

FILE: verif/tb_sector_cache_tag_lru_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sector_cache_tag_lru_controller
// Drives reads, writes and flushes into the sector cache controller, keeps a
// shadow copy of its valid, dirty, tag and stamp state, and checks every
// writeback, fill and done beat against the predicted sequence.
// ----------------------------------------------------------------------------
module tb_sector_cache_tag_lru_controller;
  import sctl_pkg::*;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] sector;
    logic [31:0] now;
  } access_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  slot;
    logic [31:0] disk_sector;
    logic        hit;
    logic        last;
  } beat_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  mode;
  logic [31:0] sector;
  logic [31:0] now;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  kind;
  logic [5:0]  slot;
  logic [31:0] disk_sector;
  logic        hit;
  logic        last;

  sector_cache_tag_lru_controller dut (.*);

  // shadow cache state
  logic        sh_valid [SLOTS];
  logic        sh_dirty [SLOTS];
  logic [31:0] sh_tag   [SLOTS];
  logic [31:0] sh_stamp [SLOTS];

  access_t pending_accesses[$];
  beat_t   expected_beats[$];
  int      mismatches;
  int      quiet_cycles;
  int      hold_off;
  bit      stim_done;
  bit      hold_req;
  bit      calm;

  function automatic int choose_victim();
    int best;
    best = 0;
    for (int i = 0; i < SLOTS; i++)
      if (!sh_valid[i]) return i;
    for (int i = 1; i < SLOTS; i++)
      if (sh_stamp[i] < sh_stamp[best]) best = i;
    return best;
  endfunction

  task automatic predict_access(input access_t a);
    int     s;
    bit     found;
    int     first;
    beat_t  b;
    s = 0;
    found = 0;
    first = expected_beats.size();
    if (a.mode == MODE_FLUSH) begin
      for (int i = 0; i < SLOTS; i++)
        if (sh_dirty[i]) begin
          b = '{KIND_WB, 6'(i), sh_tag[i], 1'b0, 1'b0};
          expected_beats.push_back(b);
          sh_dirty[i] = 0;
        end
      if (expected_beats.size() > first)
        expected_beats[expected_beats.size()-1].last = 1'b1;
    end else if (a.mode == MODE_READ || a.mode == MODE_WRITE) begin
      for (int i = 0; i < SLOTS; i++)
        if (!found && sh_valid[i] && sh_tag[i] == a.sector) begin
          s = i;
          found = 1;
        end
      if (!found) begin
        s = choose_victim();
        if (sh_valid[s] && sh_dirty[s])
          expected_beats.push_back('{KIND_WB, 6'(s), sh_tag[s], 1'b0, 1'b0});
        sh_valid[s] = 1;
        sh_dirty[s] = 0;
        sh_tag[s] = a.sector;
        expected_beats.push_back('{KIND_FILL, 6'(s), a.sector, 1'b0, 1'b0});
      end
      if (a.mode == MODE_WRITE) begin
        sh_dirty[s] = 1;
        sh_stamp[s] = a.now;
      end
      expected_beats.push_back('{KIND_DONE, 6'(s), a.sector, found, 1'b1});
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic queue_access(input logic [1:0] m, input logic [31:0] sec,
                              input logic [31:0] t);
    pending_accesses.push_back('{m, sec, t});
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // stimulus
  initial begin
    logic [31:0] tick;
    int          r;
    int          count;
    mismatches = 0;
    stim_done = 0;
    hold_req = 0;
    calm = 0;
    for (int i = 0; i < SLOTS; i++) begin
      sh_valid[i] = 0;
      sh_dirty[i] = 0;
      sh_tag[i] = '0;
      sh_stamp[i] = '0;
    end
    // directed part
    queue_access(MODE_FLUSH, 32'h0, 32'h0);          // flush with nothing dirty
    queue_access(2'd3, 32'hffff_ffff, 32'hffff_ffff); // unused mode
    queue_access(MODE_READ, 32'h0, 32'h0);
    queue_access(MODE_WRITE, 32'hffff_ffff, 32'hffff_ffff);
    queue_access(MODE_READ, 32'hffff_ffff, 32'h0);
    queue_access(MODE_WRITE, 32'h0, 32'h0);
    queue_access(MODE_WRITE, 32'haaaa_5555, 32'h5555_aaaa);
    queue_access(MODE_READ, 32'h5555_aaaa, 32'haaaa_5555);
    queue_access(MODE_FLUSH, 32'hffff_ffff, 32'hffff_ffff);
    queue_access(MODE_FLUSH, 32'h0, 32'h0);
    queue_access(2'd3, 32'h0, 32'h0);
    // random part: fill past capacity so eviction is exercised
    tick = 32'd100;
    count = 0;
    while (count < 210) begin
      r = $urandom_range(99);
      tick = tick + $urandom_range(3);
      if (r < 4) queue_access(MODE_FLUSH, $urandom, $urandom);
      else if (r < 6) queue_access(2'd3, $urandom, $urandom);
      else if (r < 10)
        queue_access(2'($urandom_range(1)), $urandom, $urandom);
      else
        queue_access(2'($urandom_range(1)), 32'($urandom_range(79)) ^
                     ($urandom_range(9) == 0 ? 32'hffff_ff00 : 32'h0),
                     ($urandom_range(19) == 0) ? $urandom : tick);
      count++;
    end
    queue_access(MODE_FLUSH, 32'h0, 32'h0);
    rst = 1;
    repeat (4) @(posedge clk);
    rst <= 0;
    // long receiver hold-off while the sender keeps offering
    repeat (30) @(posedge clk);
    hold_req <= 1;
    @(posedge clk);
    hold_req <= 0;
    repeat (600) @(posedge clk);
    calm <= 1;
    repeat (1500) @(posedge clk);
    calm <= 0;
    wait (pending_accesses.size() == 0 && !in_valid);
    stim_done = 1;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      mode <= '0;
      sector <= '0;
      now <= '0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_access('{mode, sector, now});
      if (pending_accesses.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
        access_t a;
        a = pending_accesses.pop_front();
        in_valid <= 1;
        mode <= a.mode;
        sector <= a.sector;
        now <= a.now;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver stall and monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
      hold_off <= 0;
    end else begin
      if (hold_req) hold_off <= 400;
      else if (hold_off > 0) hold_off <= hold_off - 1;
      out_stall <= (hold_req || hold_off > 1) ? 1'b1 :
                   (!calm && $urandom_range(99) < 7);
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected result beat");
        end else begin
          beat_t e;
          e = expected_beats.pop_front();
          if (kind !== e.kind)
            report_mismatch($sformatf("kind %0d exp %0d", kind, e.kind));
          if (slot !== e.slot)
            report_mismatch($sformatf("slot %0d exp %0d", slot, e.slot));
          if (disk_sector !== e.disk_sector)
            report_mismatch($sformatf("sector %h exp %h", disk_sector, e.disk_sector));
          if (hit !== e.hit)
            report_mismatch($sformatf("hit %0b exp %0b", hit, e.hit));
          if (last !== e.last)
            report_mismatch($sformatf("last %0b exp %0b", last, e.last));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (!rst && quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    out_stall = 0;
    in_valid = 0;
    mode = '0;
    sector = '0;
    now = '0;
    quiet_cycles = 0;
    wait (stim_done);
    wait (expected_beats.size() == 0);
    repeat (4 * SLOTS) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
